FILE: rtl/core/node_pool_free_list_allocator_macros.svh
// Assertion macros for the node pool allocator.
// NPFL_ASSERT: clocked check, switched off while reset is high.
// NPFL_ASSERT_ALWAYS: clocked check that also holds during reset.
`ifndef NODE_POOL_FREE_LIST_ALLOCATOR_MACROS_SVH
`define NODE_POOL_FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define NPFL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");
`define NPFL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("%m: check failed");
`else
`define NPFL_ASSERT(lbl, clk, rst, prop)
`define NPFL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/npfl_pkg.sv
`default_nettype none

package npfl_pkg;

   // field widths of the transaction ports
   localparam int unsigned MODE_W     = 1;
   localparam int unsigned IN_IDX_W   = 10;
   localparam int unsigned BYTES_W    = 23;
   localparam int unsigned NB_W       = 13;
   localparam int unsigned GRANT_W    = 10;
   localparam int unsigned FREE_OUT_W = 11;

   // divider widths: quotient as wide as the dividend, remainder as the divisor
   localparam int unsigned QUOT_W = BYTES_W;
   localparam int unsigned REM_W  = NB_W;
   localparam int unsigned WIDE_W = BYTES_W + 1;

   // smallest node size accepted by the size register
   localparam logic [NB_W-1:0] NB_MIN = NB_W'(8);

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 1'b0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 1'b1;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/npfl_link_mem.sv
`default_nettype none

module npfl_link_mem #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10,
   parameter int unsigned DATA_W = 11
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/npfl_div.sv
`default_nettype none

module npfl_div
   import npfl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [BYTES_W-1:0] dividend,
   input  wire logic [NB_W-1:0]    divisor,
   output div_stat_type            stat,
   output logic      [QUOT_W-1:0]  quot,
   output logic      [REM_W-1:0]   rem
);

   localparam int unsigned CNT_W = $clog2(BYTES_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(BYTES_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [BYTES_W-1:0] dvd_ff, dvd_in;
   logic [NB_W-1:0]    dsr_ff, dsr_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [REM_W-1:0]   rem_ff, rem_in;

   logic [REM_W:0]     part;
   logic [REM_W+1:0]   diff;
   logic               fits;

   // one restoring step: bring down the next dividend bit, trial subtract
   assign part = {rem_ff, dvd_ff[BYTES_W-1]};
   assign diff = {1'b0, part} - {2'b00, dsr_ff};
   assign fits = ~diff[REM_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         quot_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[BYTES_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         rem_in  = fits ? diff[REM_W-1:0] : part[REM_W-1:0];
         step_in = step_ff + CNT_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;
   assign rem       = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/core/node_pool_free_list_allocator.sv
// Node pool allocator: POOL_NODES equal nodes kept as a singly linked free list in an
// on-chip link memory, with a head pointer and a free count. One transaction at a time:
// req_stall stays high from acceptance until the result is placed in the output
// register, and a held result does not block acceptance of the next request. A pop
// reads the head link and then loads the result. Any request larger than one node,
// except an allocate on an empty list, first runs a shared restoring divider for the
// node count, which holds the sequencer until it is done; a multi-node allocate then
// walks the list one link per cycle through the link memory's single read port, then
// unlinks the run and loads the result, and a region release writes one link per cycle
// through its single write port. The link memory has no reset;
// entries are only read after they have been written.
`default_nettype none
`include "node_pool_free_list_allocator_macros.svh"

module node_pool_free_list_allocator
   import npfl_pkg::*;
#(
   parameter int unsigned POOL_NODES = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [IN_IDX_W-1:0]   req_node_index,
   input  wire logic [BYTES_W-1:0]    req_byte_count,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [GRANT_W-1:0]    rsp_granted_node,
   output logic                       rsp_ok,
   output logic      [FREE_OUT_W-1:0] rsp_nodes_free,
   // node size register
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [NB_W-1:0]       csr_node_bytes
);

   localparam int unsigned LINK_W = $clog2(POOL_NODES + 1);
   localparam int unsigned IDX_W  = $clog2(POOL_NODES);
   localparam int unsigned RUN_W  = LINK_W + 1;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);
   localparam logic [WIDE_W-1:0] POOL_WIDE = WIDE_W'(POOL_NODES);

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_RD,
      S_DIV_ALLOC,
      S_WALK,
      S_FOUND,
      S_DIV_REL,
      S_REL_CHECK,
      S_REL_FILL,
      S_RESP
   } state_type;

   // link memory value as seen by the list: anything out of range ends the list
   function automatic logic [LINK_W-1:0] link_clean(input logic [LINK_W-1:0] v);
      return (v < NULL_LINK) ? v : NULL_LINK;
   endfunction

   state_type             state_ff, state_in;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [LINK_W-1:0]     free_ff, free_in;
   logic [NB_W-1:0]       nb_ff, nb_in;
   logic [IN_IDX_W-1:0]   start_ff, start_in;
   logic [QUOT_W-1:0]     cnt_ff, cnt_in;
   logic [WIDE_W-1:0]     need_ff, need_in;
   logic [LINK_W-1:0]     fill_ff, fill_in;
   logic [LINK_W-1:0]     steps_ff, steps_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [IDX_W-1:0]      first_ff, first_in;
   logic [IDX_W-1:0]      last_ff, last_in;
   logic [IDX_W-1:0]      prev_ff, prev_in;
   logic                  prev_vld_ff, prev_vld_in;
   logic                  res_ok_ff, res_ok_in;
   logic [IDX_W-1:0]      res_gr_ff, res_gr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GRANT_W-1:0]    rsp_gr_ff, rsp_gr_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [FREE_OUT_W-1:0] rsp_free_ff, rsp_free_in;

   // link memory ports
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [LINK_W-1:0]     mem_wdata;
   logic [IDX_W-1:0]      mem_raddr;
   logic [LINK_W-1:0]     mem_rdata;

   // divider ports
   logic                  div_start;
   div_stat_type          div_stat;
   logic [QUOT_W-1:0]     div_quot;
   logic [REM_W-1:0]      div_rem;

   // datapath helpers
   logic                  accept;
   logic                  big;
   logic                  list_ok;
   logic [LINK_W-1:0]     rd_link;
   logic [LINK_W-1:0]     last_plus;
   logic [RUN_W-1:0]      run_inc;
   logic [LINK_W-1:0]     cnt_lo;
   logic [LINK_W-1:0]     fill_nx;
   logic [WIDE_W-1:0]     fill_addr;
   logic [WIDE_W-1:0]     fill_link;
   logic [WIDE_W-1:0]     end_wide;
   logic [WIDE_W-1:0]     total_wide;
   logic                  out_free;
   logic [IDX_W+GRANT_W-1:0]     gr_ext;
   logic [LINK_W+FREE_OUT_W-1:0] free_ext;

   assign accept    = req_valid & ~req_stall;
   assign big       = req_byte_count > BYTES_W'(nb_ff);
   assign list_ok   = (head_ff < NULL_LINK) && (free_ff != '0);
   assign rd_link   = link_clean(mem_rdata);
   assign last_plus = LINK_W'(last_ff) + LINK_W'(1);
   assign run_inc   = run_ff + RUN_W'(1);
   assign cnt_lo    = cnt_ff[LINK_W-1:0];
   assign fill_nx   = fill_ff + LINK_W'(1);
   assign fill_addr = WIDE_W'(start_ff) + WIDE_W'(fill_ff);
   assign fill_link = WIDE_W'(start_ff) + WIDE_W'(fill_nx);
   assign end_wide  = WIDE_W'(start_ff) + WIDE_W'(cnt_ff);
   assign total_wide = WIDE_W'(free_ff) + WIDE_W'(cnt_ff);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign gr_ext    = (IDX_W + GRANT_W)'(res_gr_ff);
   assign free_ext  = (LINK_W + FREE_OUT_W)'(free_ff);

   // shared divider: bytes over node size
   assign div_start = accept && big && ((req_mode == MODE_RELEASE) || list_ok);

   npfl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_byte_count),
      .divisor  (nb_ff),
      .stat     (div_stat),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   npfl_link_mem #(
      .DEPTH  (POOL_NODES),
      .ADDR_W (IDX_W),
      .DATA_W (LINK_W)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // read address: the list head to start, the link just fetched while walking
   always_comb begin
      case (state_ff)
         S_WALK:  mem_raddr = rd_link[IDX_W-1:0];
         default: mem_raddr = head_ff[IDX_W-1:0];
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      nb_in        = nb_ff;
      start_in     = start_ff;
      cnt_in       = cnt_ff;
      need_in      = need_ff;
      fill_in      = fill_ff;
      steps_in     = steps_ff;
      run_in       = run_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      prev_vld_in  = prev_vld_ff;
      res_ok_in    = res_ok_ff;
      res_gr_in    = res_gr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_gr_in    = rsp_gr_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_free_in  = rsp_free_ff;
      mem_we       = 1'b0;
      mem_waddr    = fill_addr[IDX_W-1:0];
      mem_wdata    = (fill_nx == cnt_lo) ? head_ff : fill_link[LINK_W-1:0];

      // node size register, values below the minimum are raised to it
      if (csr_valid) begin
         nb_in = (csr_node_bytes < NB_MIN) ? NB_MIN : csr_node_bytes;
      end

      // output register empties when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               start_in  = req_node_index;
               res_ok_in = 1'b0;
               res_gr_in = '0;
               if (req_mode == MODE_RELEASE) begin
                  if (big) begin
                     state_in = S_DIV_REL;
                  end else begin
                     cnt_in   = QUOT_W'(1);
                     state_in = S_REL_CHECK;
                  end
               end else if (!list_ok) begin
                  state_in = S_RESP;
               end else if (big) begin
                  state_in = S_DIV_ALLOC;
               end else begin
                  state_in = S_POP_RD;
               end
            end
         end
         // single pop: head link arrives from memory
         S_POP_RD: begin
            res_ok_in = 1'b1;
            res_gr_in = head_ff[IDX_W-1:0];
            head_in   = rd_link;
            free_in   = free_ff - LINK_W'(1);
            state_in  = S_RESP;
         end
         // run length needed is ceil(bytes / node size)
         S_DIV_ALLOC: begin
            if (div_stat.done) begin
               need_in     = WIDE_W'(div_quot) + WIDE_W'(div_rem != '0);
               first_in    = head_ff[IDX_W-1:0];
               last_in     = head_ff[IDX_W-1:0];
               prev_vld_in = 1'b0;
               steps_in    = '0;
               run_in      = RUN_W'(1);
               state_in    = S_WALK;
            end
         end
         // one list link per cycle
         S_WALK: begin
            if ((rd_link == NULL_LINK) || (steps_ff >= free_ff)) begin
               state_in = S_RESP;
            end else begin
               steps_in = steps_ff + LINK_W'(1);
               last_in  = rd_link[IDX_W-1:0];
               if (last_plus != rd_link) begin
                  prev_in     = last_ff;
                  prev_vld_in = 1'b1;
                  first_in    = rd_link[IDX_W-1:0];
                  run_in      = RUN_W'(1);
               end else begin
                  run_in = run_inc;
                  if (WIDE_W'(run_inc) >= need_ff) begin
                     state_in = S_FOUND;
                  end
               end
            end
         end
         // unlink the run: link after its last node arrives now
         S_FOUND: begin
            if (prev_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = prev_ff;
               mem_wdata = rd_link;
            end else begin
               head_in = rd_link;
            end
            if ({1'b0, free_ff} >= run_ff) begin
               free_in = LINK_W'({1'b0, free_ff} - run_ff);
            end else begin
               free_in = '0;
            end
            res_ok_in = 1'b1;
            res_gr_in = first_ff;
            state_in  = S_RESP;
         end
         // released node count is floor(bytes / node size)
         S_DIV_REL: begin
            if (div_stat.done) begin
               cnt_in   = div_quot;
               state_in = S_REL_CHECK;
            end
         end
         S_REL_CHECK: begin
            if ((end_wide > POOL_WIDE) || (total_wide > POOL_WIDE)) begin
               state_in = S_RESP;
            end else begin
               fill_in  = '0;
               state_in = S_REL_FILL;
            end
         end
         // chain the region in index order, last node points at old head
         S_REL_FILL: begin
            mem_we  = 1'b1;
            fill_in = fill_nx;
            if (fill_nx == cnt_lo) begin
               head_in   = LINK_W'(start_ff);
               free_in   = free_ff + cnt_lo;
               res_ok_in = 1'b1;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_gr_in    = gr_ext[GRANT_W-1:0];
               rsp_free_in  = free_ext[FREE_OUT_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_LINK;
         free_ff      <= '0;
         nb_ff        <= NB_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff    <= start_in;
      cnt_ff      <= cnt_in;
      need_ff     <= need_in;
      fill_ff     <= fill_in;
      steps_ff    <= steps_in;
      run_ff      <= run_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      prev_ff     <= prev_in;
      prev_vld_ff <= prev_vld_in;
      res_ok_ff   <= res_ok_in;
      res_gr_ff   <= res_gr_in;
      rsp_gr_ff   <= rsp_gr_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_node = rsp_gr_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_nodes_free   = rsp_free_ff;

   // free count and head never leave their legal range
   `NPFL_ASSERT(a_free_bound, clock, reset, free_ff <= NULL_LINK)
   `NPFL_ASSERT(a_head_bound, clock, reset, head_ff <= NULL_LINK)
   // an accepted transaction always moves the sequencer out of idle
   `NPFL_ASSERT(a_accept_busy, clock, reset, accept |=> (state_ff != S_IDLE))
   // link memory is written only while unlinking a run or filling a region
   `NPFL_ASSERT(a_write_state, clock, reset,
      mem_we |-> ((state_ff == S_FOUND) || (state_ff == S_REL_FILL)))
   // divider results only turn up while the sequencer waits for them
   `NPFL_ASSERT(a_div_wait, clock, reset,
      div_stat.done |-> ((state_ff == S_DIV_ALLOC) || (state_ff == S_DIV_REL)))
   // divider only runs while the sequencer waits for it
   `NPFL_ASSERT(a_div_busy, clock, reset,
      div_stat.busy |-> ((state_ff == S_DIV_ALLOC) || (state_ff == S_DIV_REL)))

endmodule

`default_nettype wire
